// ===== sv/pcdc_pkg.sv =====
package pcdc_pkg;

  // Field widths of the channels and registers.
  localparam int POS_W     = 10;
  localparam int FRAC_W    = 15;
  localparam int TIME_W    = 48;
  localparam int CORNER_W  = 16;
  localparam int DARK_W    = 20;
  localparam int OUT_W     = 32;
  localparam int FW_W      = 10;
  localparam int WIN_W     = 5;
  localparam int AE_W      = 16;
  localparam int IT_W      = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 48;

  // Internal arithmetic widths.
  localparam int NUM_W  = 51;  // signed time numerator and span
  localparam int MAG_W  = 50;  // magnitude of either
  localparam int HALF_W = 25;  // split point of the blend product
  localparam int PROD_W = 70;  // |num| * |end - start|
  localparam int BQ_W   = 21;  // blend quotient bits, saturated above
  localparam int DEN_W  = 21;  // 16 * average_energy
  localparam int DM_W   = 28;  // den + m, signed
  localparam int N_W    = 43;  // fraction * (den + m), signed
  localparam int CQ_W   = 32;  // correction quotient bits, saturated above

  localparam logic [DARK_W-1:0] DARK_MAX = '1;

  localparam logic [FW_W-1:0]  FW_RST  = 10'd512;
  localparam logic [WIN_W-1:0] WIN_RST = 5'd9;
  localparam logic [AE_W-1:0]  AE_RST  = 16'd1;

  typedef enum logic [1:0] {
    CMD_LOAD_START = 2'd0,
    CMD_LOAD_END   = 2'd1,
    CMD_EVENT      = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH      = 3'd0,
    CFG_WINDOW_PIXELS    = 3'd1,
    CFG_AVERAGE_ENERGY   = 3'd2,
    CFG_LAST_EVENT_TIME  = 3'd3,
    CFG_INTEGRATION_TIME = 3'd4
  } cfg_idx_t;

  // Item state carried alongside the blend divider.
  typedef struct packed {
    logic [DARK_W-1:0]       start_dark;
    logic                    neg;
    logic                    in_rng;
    logic                    span_zero;
    logic [POS_W-1:0]        x_pos;
    logic [POS_W-1:0]        y_pos;
    logic signed [FRAC_W-1:0] x_fraction;
    logic signed [FRAC_W-1:0] y_fraction;
    logic [CORNER_W-1:0]     corner_minimum;
  } blend_side_t;

  // Item state carried alongside one axis of the correction.
  typedef struct packed {
    logic [DARK_W-1:0] dark;
    logic              span_zero;
  } res_side_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] x_corrected;
    logic signed [OUT_W-1:0] y_corrected;
    logic [DARK_W-1:0]       dark_used;
    logic                    span_error;
  } res_t;

endpackage

// ===== sv/pcdc_if.sv =====
interface pcdc_in_if import pcdc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic [POS_W-1:0]         x_pos;
  logic [POS_W-1:0]         y_pos;
  logic signed [FRAC_W-1:0] x_fraction;
  logic signed [FRAC_W-1:0] y_fraction;
  logic [TIME_W-1:0]        event_time;
  logic [CORNER_W-1:0]      corner_minimum;
  logic [DARK_W-1:0]        dark_level;

  modport source (output valid, cmd, x_pos, y_pos, x_fraction, y_fraction, event_time,
                  corner_minimum, dark_level, input ready);
  modport sink (input valid, cmd, x_pos, y_pos, x_fraction, y_fraction, event_time,
                corner_minimum, dark_level, output ready);
endinterface

interface pcdc_out_if import pcdc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] x_corrected;
  logic signed [OUT_W-1:0] y_corrected;
  logic [DARK_W-1:0]       dark_used;
  logic                    span_error;

  modport source (output valid, x_corrected, y_corrected, dark_used, span_error,
                  input ready);
  modport sink (input valid, x_corrected, y_corrected, dark_used, span_error,
                output ready);
endinterface

// ===== sv/pcdc_ram.sv =====
module pcdc_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/pcdc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage. The quotient is
// saturated at 2^QW: the first stage flags a numerator at or above den * 2^QW.
module pcdc_div #(
  parameter int NW = 70,
  parameter int DW = 50,
  parameter int QW = 21,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW:0]   quo,
  output logic [SW-1:0] side_out
);

  localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic          vld_r  [0:QW];
  logic [NW-1:0] rem_r  [0:QW-1];
  logic [DW-1:0] den_r  [0:QW-1];
  logic [QW-1:0] q_r    [0:QW];
  logic          sat_r  [0:QW];
  logic [SW-1:0] side_r [0:QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= num;
      den_r[0]  <= den;
      q_r[0]    <= '0;
      sat_r[0]  <= CW'(num) >= (CW'(den) << QW);
      side_r[0] <= side_in;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_stage
    localparam int B = QW - j;
    logic [CW-1:0] dsh;
    logic          ge;

    assign dsh = CW'(den_r[j-1]) << B;
    assign ge  = CW'(rem_r[j-1]) >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[j]    <= q_r[j-1] | (QW'(ge) << B);
        sat_r[j]  <= sat_r[j-1];
        side_r[j] <= side_r[j-1];
      end
    end

    if (j < QW) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= ge ? NW'(CW'(rem_r[j-1]) - dsh) : rem_r[j-1];
          den_r[j] <= den_r[j-1];
        end
      end
    end
  end

  assign out_valid = vld_r[QW];
  assign quo       = sat_r[QW] ? ((QW+1)'(1) << QW) : {1'b0, q_r[QW]};
  assign side_out  = side_r[QW];

endmodule

// ===== sv/pcdc_axis.sv =====
// One coordinate of the correction:
// round(frac * (den + m) / den) + pos * 2^14, saturated to 32 bits.
module pcdc_axis import pcdc_pkg::*; #(
  parameter int SW = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [FRAC_W-1:0] frac,
  input  logic [POS_W-1:0]         pos,
  input  logic [DEN_W-1:0]         den,
  input  logic signed [DM_W-1:0]   dm,
  input  logic [SW-1:0]            side_in,
  output logic                     out_valid,
  output logic signed [OUT_W-1:0]  corr,
  output logic [SW-1:0]            side_out
);

  localparam int DSW = SW + POS_W + 1;
  localparam int SQ_W = CQ_W + 2;
  localparam int SUM_W = CQ_W + 3;

  logic                   g_vld_r;
  logic signed [N_W-1:0]  g_n_r;
  logic [DEN_W-1:0]       g_den_r;
  logic [POS_W-1:0]       g_pos_r;
  logic [SW-1:0]          g_side_r;

  logic                   h_vld_r;
  logic [N_W-1:0]         h_mag_r;
  logic [DEN_W-1:0]       h_den_r;
  logic [DSW-1:0]         h_side_r;

  logic                   d_vld;
  logic [CQ_W:0]          d_quo;
  logic [DSW-1:0]         d_side;

  logic                   i_vld_r;
  logic signed [OUT_W-1:0] i_corr_r;
  logic [SW-1:0]          i_side_r;

  logic [N_W-1:0]          n_abs;
  logic signed [SQ_W-1:0]  sq;
  logic signed [SUM_W-1:0] sum;
  logic signed [OUT_W-1:0] sat;
  logic                    d_neg;
  logic [POS_W-1:0]        d_pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
      h_vld_r <= 1'b0;
      i_vld_r <= 1'b0;
    end else if (en) begin
      g_vld_r <= in_valid;
      h_vld_r <= g_vld_r;
      i_vld_r <= d_vld;
    end
  end

  assign n_abs = g_n_r[N_W-1] ? N_W'(-g_n_r) : N_W'(g_n_r);

  always_ff @(posedge clk) begin
    if (en) begin
      g_n_r    <= N_W'(frac * dm);
      g_den_r  <= den;
      g_pos_r  <= pos;
      g_side_r <= side_in;
      // Half the divisor is added for rounding to nearest, halves away from zero.
      h_mag_r  <= n_abs + N_W'(g_den_r >> 1);
      h_den_r  <= g_den_r;
      h_side_r <= {g_n_r[N_W-1], g_pos_r, g_side_r};
    end
  end

  pcdc_div #(
    .NW (N_W),
    .DW (DEN_W),
    .QW (CQ_W),
    .SW (DSW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (h_vld_r),
    .num       (h_mag_r),
    .den       (h_den_r),
    .side_in   (h_side_r),
    .out_valid (d_vld),
    .quo       (d_quo),
    .side_out  (d_side)
  );

  assign d_neg = d_side[DSW-1];
  assign d_pos = d_side[SW +: POS_W];
  assign sq    = d_neg ? -$signed({1'b0, d_quo}) : $signed({1'b0, d_quo});
  assign sum   = SUM_W'(sq) + $signed({{(SUM_W-POS_W-14){1'b0}}, d_pos, 14'd0});

  always_comb begin
    if (sum > SUM_W'($signed({1'b0, {(OUT_W-1){1'b1}}}))) begin
      sat = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (sum < -SUM_W'($signed({1'b0, 1'b1, {(OUT_W-1){1'b0}}}))) begin
      sat = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      sat = OUT_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_corr_r <= sat;
      i_side_r <= d_side[SW-1:0];
    end
  end

  assign out_valid = i_vld_r;
  assign corr      = i_corr_r;
  assign side_out  = i_side_r;

endmodule

// ===== sv/photon_centroid_dark_correction.sv =====
// Dark-frame corrected photon centroids. Loads (cmd 0 and 1) write one pixel
// of the start or end dark frame; events (cmd 2) produce one corrected item
// each, loads and cmd 3 produce none. The block accepts one item per clock,
// and an event passes through the two bit-per-stage dividers (22 register
// stages for the time blend of the dark value, 33 for the energy correction)
// plus ten other register stages, one of them the dark-frame memory read.
// Both dark frames live in single-port-write memories of DARK_DIM*DARK_DIM
// entries; their contents are undefined until loaded, and no clearing pass
// runs. Output is held in a register with a skid stage behind it, so input is
// only stalled once both are full. Configuration registers are to be written
// only while no event is in flight; the user is bound to this, as the block
// itself does not enforce it.
module photon_centroid_dark_correction import pcdc_pkg::*; #(
  parameter int DARK_DIM = 512
) (
  input  logic                 clk,
  input  logic                 rst_n,
  pcdc_in_if.sink              in_ch,
  pcdc_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Offset coordinates span -1023 .. 2047 for any store size up to 1024.
  localparam int IW    = POS_W + 2;
  localparam int DEPTH = DARK_DIM * DARK_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int BSW   = $bits(blend_side_t);
  localparam int RSW   = $bits(res_side_t);
  localparam int V_W   = DARK_W + 4;

  // Configuration registers.
  logic [FW_W-1:0]   frame_width_r;
  logic [WIN_W-1:0]  window_pixels_r;
  logic [AE_W-1:0]   average_energy_r;
  logic [TIME_W-1:0] last_event_time_r;
  logic [IT_W-1:0]   integration_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r      <= FW_RST;
      window_pixels_r    <= WIN_RST;
      average_energy_r   <= AE_RST;
      last_event_time_r  <= '0;
      integration_time_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_WIDTH:      frame_width_r      <= cfg_data[FW_W-1:0];
        CFG_WINDOW_PIXELS:    window_pixels_r    <= cfg_data[WIN_W-1:0];
        CFG_AVERAGE_ENERGY:   average_energy_r   <= cfg_data[AE_W-1:0];
        CFG_LAST_EVENT_TIME:  last_event_time_r  <= cfg_data[TIME_W-1:0];
        CFG_INTEGRATION_TIME: integration_time_r <= cfg_data[IT_W-1:0];
        default: ;
      endcase
    end
  end

  // Output register and skid stage.
  logic out_valid_r;
  res_t out_r;
  logic sk_valid_r;
  res_t sk_r;
  logic adv;

  assign adv         = !sk_valid_r;
  assign in_ch.ready = adv;

  // Stage A: decode, dark-store address and time terms.
  logic                   in_acc;
  logic                   is_ev;
  logic                   is_ld;
  logic signed [IW-1:0]   shift;
  logic signed [IW-1:0]   ix;
  logic signed [IW-1:0]   iy;
  logic                   ev_rng;
  logic                   ld_rng;
  logic [IW-1:0]          sel_x;
  logic [IW-1:0]          sel_y;
  logic signed [NUM_W-1:0] num;
  logic signed [NUM_W-1:0] span;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign is_ev  = cmd_t'(in_ch.cmd) == CMD_EVENT;
  assign is_ld  = cmd_t'(in_ch.cmd) == CMD_LOAD_START || cmd_t'(in_ch.cmd) == CMD_LOAD_END;
  assign shift  = $signed(IW'(frame_width_r)) - $signed(IW'(DARK_DIM));
  assign ix     = $signed(IW'(in_ch.x_pos)) - shift;
  assign iy     = $signed(IW'(in_ch.y_pos)) - shift;
  assign ev_rng = !ix[IW-1] && !iy[IW-1] && (ix < $signed(IW'(DARK_DIM)))
                  && (iy < $signed(IW'(DARK_DIM)));
  assign ld_rng = (IW'(in_ch.x_pos) < IW'(DARK_DIM)) && (IW'(in_ch.y_pos) < IW'(DARK_DIM));
  assign sel_x  = is_ev ? ix : IW'(in_ch.x_pos);
  assign sel_y  = is_ev ? iy : IW'(in_ch.y_pos);
  assign num    = $signed(NUM_W'(last_event_time_r)) - $signed(NUM_W'(in_ch.event_time))
                  + $signed(NUM_W'(integration_time_r));
  assign span   = num + $signed(NUM_W'(integration_time_r));

  logic                     a_vld_r;
  logic                     a_we_r;
  logic                     a_end_r;
  logic [AW-1:0]            a_addr_r;
  logic [DARK_W-1:0]        a_level_r;
  logic                     a_rng_r;
  logic signed [NUM_W-1:0]  a_num_r;
  logic signed [NUM_W-1:0]  a_span_r;
  logic [POS_W-1:0]         a_xp_r;
  logic [POS_W-1:0]         a_yp_r;
  logic signed [FRAC_W-1:0] a_xf_r;
  logic signed [FRAC_W-1:0] a_yf_r;
  logic [CORNER_W-1:0]      a_corner_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      a_we_r  <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_acc && is_ev;
      a_we_r  <= in_acc && is_ld && ld_rng;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_end_r    <= cmd_t'(in_ch.cmd) == CMD_LOAD_END;
      a_addr_r   <= AW'(sel_y) * AW'(DARK_DIM) + AW'(sel_x);
      a_level_r  <= in_ch.dark_level;
      a_rng_r    <= ev_rng;
      a_num_r    <= num;
      a_span_r   <= span;
      a_xp_r     <= in_ch.x_pos;
      a_yp_r     <= in_ch.y_pos;
      a_xf_r     <= in_ch.x_fraction;
      a_yf_r     <= in_ch.y_fraction;
      a_corner_r <= in_ch.corner_minimum;
    end
  end

  // Dark stores. Writes and reads both come from stage A, so item order holds.
  logic [DARK_W-1:0] start_q;
  logic [DARK_W-1:0] end_q;

  pcdc_ram #(.WIDTH(DARK_W), .DEPTH(DEPTH)) u_start_ram (
    .clk   (clk),
    .we    (adv && a_we_r && !a_end_r),
    .waddr (a_addr_r),
    .wdata (a_level_r),
    .re    (adv),
    .raddr (a_addr_r),
    .rdata (start_q)
  );

  pcdc_ram #(.WIDTH(DARK_W), .DEPTH(DEPTH)) u_end_ram (
    .clk   (clk),
    .we    (adv && a_we_r && a_end_r),
    .waddr (a_addr_r),
    .wdata (a_level_r),
    .re    (adv),
    .raddr (a_addr_r),
    .rdata (end_q)
  );

  // Stage B: magnitudes, aligned with the memory read data.
  logic                     b_vld_r;
  logic [MAG_W-1:0]         b_an_r;
  logic [MAG_W-1:0]         b_as_r;
  logic                     b_neg_r;
  logic                     b_zero_r;
  logic                     b_rng_r;
  logic [POS_W-1:0]         b_xp_r;
  logic [POS_W-1:0]         b_yp_r;
  logic signed [FRAC_W-1:0] b_xf_r;
  logic signed [FRAC_W-1:0] b_yf_r;
  logic [CORNER_W-1:0]      b_corner_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_an_r     <= a_num_r[NUM_W-1] ? MAG_W'(-a_num_r) : MAG_W'(a_num_r);
      b_as_r     <= a_span_r[NUM_W-1] ? MAG_W'(-a_span_r) : MAG_W'(a_span_r);
      b_neg_r    <= a_num_r[NUM_W-1] ^ a_span_r[NUM_W-1];
      b_zero_r   <= a_span_r == '0;
      b_rng_r    <= a_rng_r;
      b_xp_r     <= a_xp_r;
      b_yp_r     <= a_yp_r;
      b_xf_r     <= a_xf_r;
      b_yf_r     <= a_yf_r;
      b_corner_r <= a_corner_r;
    end
  end

  // Stage C: dark difference and the two halves of |num| * |diff|.
  logic signed [DARK_W:0] diff;
  logic [DARK_W-1:0]      ad;

  assign diff = $signed({1'b0, end_q}) - $signed({1'b0, start_q});
  assign ad   = diff[DARK_W] ? DARK_W'(-diff) : DARK_W'(diff);

  logic                          c_vld_r;
  logic [HALF_W+DARK_W-1:0]      c_pl_r;
  logic [MAG_W-HALF_W+DARK_W-1:0] c_ph_r;
  logic [MAG_W-1:0]              c_as_r;
  blend_side_t                   c_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_pl_r                  <= b_an_r[HALF_W-1:0] * ad;
      c_ph_r                  <= b_an_r[MAG_W-1:HALF_W] * ad;
      c_as_r                  <= b_as_r;
      c_side_r.start_dark     <= start_q;
      c_side_r.neg            <= b_neg_r ^ diff[DARK_W];
      c_side_r.in_rng         <= b_rng_r;
      c_side_r.span_zero      <= b_zero_r;
      c_side_r.x_pos          <= b_xp_r;
      c_side_r.y_pos          <= b_yp_r;
      c_side_r.x_fraction     <= b_xf_r;
      c_side_r.y_fraction     <= b_yf_r;
      c_side_r.corner_minimum <= b_corner_r;
    end
  end

  // Stage D: full product.
  logic              d_vld_r;
  logic [PROD_W-1:0] d_prod_r;
  logic [MAG_W-1:0]  d_as_r;
  blend_side_t       d_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (adv) begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_prod_r <= PROD_W'(c_pl_r) + (PROD_W'(c_ph_r) << HALF_W);
      d_as_r   <= c_as_r;
      d_side_r <= c_side_r;
    end
  end

  // Blend quotient. A zero span goes through as a saturated quotient and is
  // overridden at the output.
  logic           q_vld;
  logic [BQ_W:0]  q_quo;
  logic [BSW-1:0] q_side_bits;
  blend_side_t    q_side;

  pcdc_div #(
    .NW (PROD_W),
    .DW (MAG_W),
    .QW (BQ_W),
    .SW (BSW)
  ) u_blend_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (d_vld_r),
    .num       (d_prod_r),
    .den       (d_as_r),
    .side_in   (d_side_r),
    .out_valid (q_vld),
    .quo       (q_quo),
    .side_out  (q_side_bits)
  );

  assign q_side = blend_side_t'(q_side_bits);

  // Stage E: blended dark value, clamped.
  logic signed [V_W-1:0] v;
  logic [DARK_W-1:0]     v_clamp;

  assign v = q_side.neg ? $signed(V_W'(q_side.start_dark)) - $signed(V_W'(q_quo))
                        : $signed(V_W'(q_side.start_dark)) + $signed(V_W'(q_quo));

  always_comb begin
    if (v[V_W-1]) begin
      v_clamp = '0;
    end else if (v > $signed(V_W'(DARK_MAX))) begin
      v_clamp = DARK_MAX;
    end else begin
      v_clamp = DARK_W'(v);
    end
  end

  logic                     e_vld_r;
  logic [DARK_W-1:0]        e_dark_r;
  logic                     e_zero_r;
  logic [POS_W-1:0]         e_xp_r;
  logic [POS_W-1:0]         e_yp_r;
  logic signed [FRAC_W-1:0] e_xf_r;
  logic signed [FRAC_W-1:0] e_yf_r;
  logic [CORNER_W-1:0]      e_corner_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (adv) begin
      e_vld_r <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_dark_r   <= q_side.in_rng ? v_clamp : '0;
      e_zero_r   <= q_side.span_zero;
      e_xp_r     <= q_side.x_pos;
      e_yp_r     <= q_side.y_pos;
      e_xf_r     <= q_side.x_fraction;
      e_yf_r     <= q_side.y_fraction;
      e_corner_r <= q_side.corner_minimum;
    end
  end

  // Stage F: (dark - 16 * corner) * window, plus the energy divisor.
  logic signed [DARK_W+1:0] dd;
  logic signed [DM_W-1:0]   m;
  logic [DEN_W-1:0]         den;

  assign dd  = $signed({2'b00, e_dark_r}) - $signed({2'b00, e_corner_r, 4'd0});
  assign m   = DM_W'(dd * $signed({1'b0, window_pixels_r}));
  assign den = (average_energy_r == '0) ? DEN_W'(16) : {1'b0, average_energy_r, 4'd0};

  logic                     f_vld_r;
  logic signed [DM_W-1:0]   f_dm_r;
  logic [DEN_W-1:0]         f_den_r;
  logic [POS_W-1:0]         f_xp_r;
  logic [POS_W-1:0]         f_yp_r;
  logic signed [FRAC_W-1:0] f_xf_r;
  logic signed [FRAC_W-1:0] f_yf_r;
  res_side_t                f_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (adv) begin
      f_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_dm_r             <= $signed(DM_W'(den)) + m;
      f_den_r            <= den;
      f_xp_r             <= e_xp_r;
      f_yp_r             <= e_yp_r;
      f_xf_r             <= e_xf_r;
      f_yf_r             <= e_yf_r;
      f_side_r.dark      <= e_dark_r;
      f_side_r.span_zero <= e_zero_r;
    end
  end

  // Both axes run in lockstep; the x axis carries the shared result fields.
  logic                    x_vld;
  logic                    y_vld;
  logic signed [OUT_W-1:0] x_corr;
  logic signed [OUT_W-1:0] y_corr;
  logic [RSW-1:0]          x_side_bits;
  logic                    y_side_unused;
  res_side_t               r_side;

  pcdc_axis #(.SW(RSW)) u_axis_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (f_vld_r),
    .frac      (f_xf_r),
    .pos       (f_xp_r),
    .den       (f_den_r),
    .dm        (f_dm_r),
    .side_in   (f_side_r),
    .out_valid (x_vld),
    .corr      (x_corr),
    .side_out  (x_side_bits)
  );

  pcdc_axis #(.SW(1)) u_axis_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (f_vld_r),
    .frac      (f_yf_r),
    .pos       (f_yp_r),
    .den       (f_den_r),
    .dm        (f_dm_r),
    .side_in   (f_side_r.span_zero),
    .out_valid (y_vld),
    .corr      (y_corr),
    .side_out  (y_side_unused)
  );

  assign r_side = res_side_t'(x_side_bits);

  res_t res;
  logic res_valid;

  assign res_valid = adv && x_vld && y_vld;

  always_comb begin
    if (r_side.span_zero || y_side_unused) begin
      res.x_corrected = '0;
      res.y_corrected = '0;
      res.dark_used   = '0;
      res.span_error  = 1'b1;
    end else begin
      res.x_corrected = x_corr;
      res.y_corrected = y_corr;
      res.dark_used   = r_side.dark;
      res.span_error  = 1'b0;
    end
  end

  // Output register with skid stage.
  logic take_out;

  assign take_out = out_valid_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else if (sk_valid_r) begin
      if (take_out) begin
        sk_valid_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || take_out) begin
        out_valid_r <= 1'b1;
      end else begin
        sk_valid_r <= 1'b1;
      end
    end else if (take_out) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_valid_r) begin
      if (take_out) begin
        out_r <= sk_r;
      end
    end else if (res_valid) begin
      if (!out_valid_r || take_out) begin
        out_r <= res;
      end else begin
        sk_r <= res;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.x_corrected = out_r.x_corrected;
  assign out_ch.y_corrected = out_r.y_corrected;
  assign out_ch.dark_used   = out_r.dark_used;
  assign out_ch.span_error  = out_r.span_error;

  // The skid stage only ever holds an item behind a held output item.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_valid_r |-> out_valid_r)
    else $error("skid stage holds an item while the output register is empty");

  // The skid stage fills only when the output item was stalled.
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    sk_valid_r && !$past(sk_valid_r) |-> $past(out_valid_r && !out_ch.ready))
    else $error("skid stage filled without an output stall");

  // A zero time span forces all result fields to zero.
  a_span_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.span_error |->
      out_r.x_corrected == '0 && out_r.y_corrected == '0 && out_r.dark_used == '0)
    else $error("span error item carries nonzero fields");

  // Both axes stay in lockstep.
  a_axis_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    x_vld == y_vld)
    else $error("x and y correction pipelines out of step");

endmodule
